// ===== design/lppf_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lppf_pkg: shared types and constants of the length-prefixed packet FIFO
// Holds the ring geometry, the operation and status codes, the controller
// state type and the command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package lppf_pkg;

  // Ring depth in bytes. It must be a power of two so that indexes wrap freely.
  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int LEN_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int MAX_LEN = 62;
  // Width that holds used slots plus a length plus two without overflow.
  localparam int SUM_W   = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 2;

  typedef enum logic [1:0] {
    OP_PUSH_START = 2'd0,
    OP_PUSH_BYTE  = 2'd1,
    OP_POP        = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    STS_BYTE   = 3'd0,
    STS_IDLE   = 3'd1,
    STS_ACCEPT = 3'd2,
    STS_REJECT = 3'd3,
    STS_EMPTY  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_HEADER = 2'd1,
    S_STREAM = 2'd2
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    push_start;  // begin a push; store the length byte if push_ok
    logic    push_ok;     // the packet fits
    logic    store_data;  // store one data byte of the open push
    logic    drop_byte;   // discard one data byte of a rejected push
    logic    rd_step;     // read the byte at the read index and advance it
    logic    load_cnt;    // load the byte count from the header just read
    logic    dec_cnt;     // one data byte has been streamed
    logic    emit;        // register a result this cycle
    status_t emit_status;
    logic    emit_data;   // result carries the byte just read
    logic    emit_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic push_open;
    logic push_dropping;
    logic push_fits;
    logic ring_empty;
    logic hdr_zero;
    logic cnt_last;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== design/lppf_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lppf_ctrl: controller of the length-prefixed packet FIFO
// Decodes each accepted operation and sequences the header read and the
// byte stream of a pop.
// ---------------------------------------------------------------------------
module lppf_ctrl
  import lppf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] in_op,
  input  wire logic       in_tx_busy,
  input  wire dp_status_t sts,
  output dp_cmd_t         cmd,
  output logic            busy
);

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emit_status = STS_IDLE;
    busy      = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (op_t'(in_op))
            OP_PUSH_START: begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              if (sts.push_open) begin
                cmd.emit_status = STS_REJECT;
              end else begin
                cmd.push_start  = 1'b1;
                cmd.push_ok     = sts.push_fits;
                cmd.emit_status = sts.push_fits ? STS_ACCEPT : STS_REJECT;
              end
            end
            OP_PUSH_BYTE: begin
              if (sts.push_open) begin
                cmd.store_data  = 1'b1;
                cmd.emit        = 1'b1;
                cmd.emit_last   = 1'b1;
                cmd.emit_status = STS_ACCEPT;
              end else if (sts.push_dropping) begin
                cmd.drop_byte = 1'b1;
              end
            end
            OP_POP: begin
              if (in_tx_busy || sts.ring_empty || sts.push_open) begin
                cmd.emit        = 1'b1;
                cmd.emit_last   = 1'b1;
                cmd.emit_status = STS_IDLE;
              end else begin
                cmd.rd_step = 1'b1;
                state_nxt   = S_HEADER;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_HEADER: begin
        if (sts.hdr_zero) begin
          cmd.emit        = 1'b1;
          cmd.emit_last   = 1'b1;
          cmd.emit_status = STS_EMPTY;
          state_nxt       = S_IDLE;
        end else begin
          cmd.rd_step  = 1'b1;
          cmd.load_cnt = 1'b1;
          state_nxt    = S_STREAM;
        end
      end
      S_STREAM: begin
        cmd.emit        = 1'b1;
        cmd.emit_data   = 1'b1;
        cmd.emit_status = STS_BYTE;
        cmd.emit_last   = sts.cnt_last;
        if (sts.cnt_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_step = 1'b1;
          cmd.dec_cnt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Every streaming cycle delivers exactly one byte.
  a_stream_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STREAM) |-> (cmd.emit && cmd.emit_data))
    else $error("stream cycle without a delivered byte");

  // A pop never starts while a push is still open.
  a_pop_not_during_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && state_nxt == S_HEADER) |-> !sts.push_open)
    else $error("pop started during an open push");

endmodule
`default_nettype wire

// ===== design/lppf_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lppf_datapath: byte ring, indexes, push bookkeeping and result register
// Executes the controller's commands on the single-port byte store.
// ---------------------------------------------------------------------------
module lppf_datapath
  import lppf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dp_cmd_t           cmd,
  input  wire logic [LEN_W-1:0]  in_pkt_length,
  input  wire logic [BYTE_W-1:0] in_data_in,
  output dp_status_t             sts,
  output logic                   out_valid,
  output logic [2:0]             out_status,
  output logic [BYTE_W-1:0]      out_data_out,
  output logic                   out_last
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  logic [IDX_W-1:0]  rd_r, rd_nxt;
  logic [IDX_W-1:0]  wr_r, wr_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic              open_r, open_nxt;
  logic              drop_r, drop_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [BYTE_W-1:0] out_data_r;
  logic              out_last_r;

  logic              we;
  logic [BYTE_W-1:0] wdata;
  logic [IDX_W-1:0]  used;
  logic [SUM_W-1:0]  need;
  logic [LEN_W-1:0]  hdr_len;

  // Space check keeps one slot free: used + length + 2 must not exceed DEPTH.
  assign used = wr_r - rd_r;
  assign need = SUM_W'(used) + SUM_W'(in_pkt_length) + SUM_W'(2);
  assign hdr_len = (rdata_r > BYTE_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : rdata_r[LEN_W-1:0];

  assign sts.push_open     = open_r;
  assign sts.push_dropping = drop_r;
  assign sts.push_fits     = (in_pkt_length <= LEN_W'(MAX_LEN)) && (need <= SUM_W'(DEPTH));
  assign sts.ring_empty    = (wr_r == rd_r);
  assign sts.hdr_zero      = (rdata_r == '0);
  assign sts.cnt_last      = (cnt_r == LEN_W'(1));

  assign we    = (cmd.push_start && cmd.push_ok) || cmd.store_data;
  assign wdata = cmd.store_data ? in_data_in : BYTE_W'(in_pkt_length);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_r] <= wdata;
    end
    if (cmd.rd_step) begin
      rdata_r <= mem[rd_r];
    end
  end

  always_comb begin
    rd_nxt   = rd_r;
    wr_nxt   = wr_r;
    left_nxt = left_r;
    open_nxt = open_r;
    drop_nxt = drop_r;
    cnt_nxt  = cnt_r;
    if (we) begin
      wr_nxt = wr_r + IDX_W'(1);
    end
    if (cmd.push_start) begin
      left_nxt = in_pkt_length;
      open_nxt = cmd.push_ok && (in_pkt_length != '0);
      drop_nxt = !cmd.push_ok && (in_pkt_length != '0);
    end
    if (cmd.store_data) begin
      left_nxt = left_r - LEN_W'(1);
      if (left_r == LEN_W'(1)) begin
        open_nxt = 1'b0;
      end
    end
    if (cmd.drop_byte) begin
      left_nxt = left_r - LEN_W'(1);
      if (left_r == LEN_W'(1)) begin
        drop_nxt = 1'b0;
      end
    end
    if (cmd.rd_step) begin
      rd_nxt = rd_r + IDX_W'(1);
    end
    if (cmd.load_cnt) begin
      cnt_nxt = hdr_len;
    end else if (cmd.dec_cnt) begin
      cnt_nxt = cnt_r - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r        <= '0;
      wr_r        <= '0;
      left_r      <= '0;
      open_r      <= 1'b0;
      drop_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_r        <= rd_nxt;
      wr_r        <= wr_nxt;
      left_r      <= left_nxt;
      open_r      <= open_nxt;
      drop_r      <= drop_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_data_r   <= cmd.emit_data ? rdata_r : '0;
      out_last_r   <= cmd.emit_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_data_out = out_data_r;
  assign out_last     = out_last_r;

  // An open push and a drop never coexist.
  a_open_xor_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !(open_r && drop_r))
    else $error("push open and push dropping both set");

  // After any store one slot stays free, so the ring cannot look empty.
  a_store_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    we |=> (wr_r != rd_r))
    else $error("ring looks empty right after a store");

  // Ring writes and reads never share a cycle on the single port.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> !cmd.rd_step)
    else $error("write and read in the same cycle");

endmodule
`default_nettype wire

// ===== design/length_prefixed_packet_fifo.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// length_prefixed_packet_fifo: byte ring of variable-length packets
// Top level joining the controller and the datapath.
// ---------------------------------------------------------------------------
// An operation is taken at a rising edge with start high and busy low. Every
// result appears on the out_ ports for exactly one cycle with out_valid high;
// the receiver cannot stall, so it must take each transfer as it comes. Push
// operations (start, byte) and a blocked pop leave busy low and can be issued
// back to back; their result is registered and appears in the next cycle, but
// a dropped byte or one with no push open gives no result. A pop keeps busy
// high through the header state and then the stream state: the single read
// port of the byte store first fetches the length byte and then one data
// byte per cycle, and the bytes come out at one per cycle. The ring holds
// DEPTH bytes, of which one always stays free; a packet occupies its length
// plus one. The store needs no clearing after reset.
// ---------------------------------------------------------------------------
module length_prefixed_packet_fifo
  import lppf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_op,
  input  wire logic [LEN_W-1:0]  in_pkt_length,
  input  wire logic [BYTE_W-1:0] in_data_in,
  input  wire logic              in_tx_busy,
  output logic                   out_valid,
  output logic [2:0]             out_status,
  output logic [BYTE_W-1:0]      out_data_out,
  output logic                   out_last
);

  // Commands flow from the controller; status flags flow back.
  dp_cmd_t    cmd;
  dp_status_t sts;

  lppf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_op      (in_op),
    .in_tx_busy (in_tx_busy),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  // The datapath owns the byte store, both ring indexes and the result
  // register, so each result is a registered transfer.
  lppf_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_pkt_length (in_pkt_length),
    .in_data_in    (in_data_in),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_data_out  (out_data_out),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire

// ===== test/length_prefixed_packet_fifo_test.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// length_prefixed_packet_fifo_test: self-checking bench for the packet FIFO
// Feeds push, byte, pop and unused commands through the start/busy port,
// predicts every result from a shadow copy of the ring, and compares each
// strobed result field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module length_prefixed_packet_fifo_test;
  import lppf_pkg::*;

  // The unused operation code. The block must ignore it.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // A length one above the largest legal packet, with every length bit set.
  localparam int unsigned OVER_LEN = 63;

  // Counted items added after the opening sequence.
  localparam int unsigned RANDOM_ITEMS   = 88;

  // Longest quiet stretch allowed before the run fails; it must cover the
  // sender's longest random gap (a run of idle draws at 63 percent) plus the
  // registered result. Pops stream one result per cycle, so a long packet keeps
  // the bench busy, not quiet.
  localparam int unsigned QUIET_LIMIT = 2000;
  // Wait well past the pop of the largest packet.
  localparam int unsigned DRAIN_CYCLES = 2 * MAX_LEN + 8;

  typedef struct packed {
    logic [1:0]        op;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] data;
    logic              tx_busy;
    int unsigned       idle_pct;
  } fifo_cmd_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] data;
    logic              last;
  } fifo_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_op = OP_UNUSED;
  logic [LEN_W-1:0]  in_pkt_length = '0;
  logic [BYTE_W-1:0] in_data_in = '0;
  logic              in_tx_busy = 1'b0;
  logic              out_valid;
  logic [2:0]        out_status;
  logic [BYTE_W-1:0] out_data_out;
  logic              out_last;

  length_prefixed_packet_fifo u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_pkt_length(in_pkt_length),
    .in_data_in   (in_data_in),
    .in_tx_busy   (in_tx_busy),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_data_out (out_data_out),
    .out_last     (out_last)
  );

  // Commands waiting to be driven; the head is the one on the ports while
  // start is high.
  fifo_cmd_t    pending_cmds[$];
  // Results the shadow ring says are still owed, oldest first.
  fifo_result_t awaited_results[$];

  int unsigned mismatch_count = 0;
  int unsigned counted_items  = 0;
  int unsigned cur_idle_pct   = 0;
  int unsigned quiet_cycles   = 0;

  // Shadow copy of the ring and the push bookkeeping. It starts out in the
  // reset state, and reset is applied only once.
  logic [BYTE_W-1:0] shadow_ring [DEPTH];
  logic [IDX_W-1:0]  shadow_rd = '0;
  logic [IDX_W-1:0]  shadow_wr = '0;
  logic [LEN_W-1:0]  shadow_due = '0;
  logic              shadow_open = 1'b0;
  logic              shadow_dropping = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  function automatic void owe_result(input status_t status, input logic [BYTE_W-1:0] data,
                                     input logic last);
    fifo_result_t r;
    r.status = status;
    r.data   = data;
    r.last   = last;
    awaited_results.push_back(r);
  endfunction

  // Applies one accepted command to the shadow ring and records every result
  // it must produce.
  function automatic void predict_fifo_op(input fifo_cmd_t cmd);
    logic [IDX_W-1:0]  used_slots;
    int unsigned       free_slots;
    logic [BYTE_W-1:0] hdr;
    case (cmd.op)
      OP_PUSH_START: begin
        if (shadow_open) begin
          // A second start while a push is open is refused; the open one goes on.
          owe_result(STS_REJECT, '0, 1'b1);
        end else begin
          // Any drop in progress is abandoned by a fresh start.
          shadow_dropping = 1'b0;
          shadow_due      = '0;
          used_slots      = shadow_wr - shadow_rd;
          free_slots      = DEPTH - int'(used_slots);
          // The packet takes its length plus a header, and one slot stays free.
          if (cmd.len > MAX_LEN || cmd.len + 2 > free_slots) begin
            if (cmd.len != 0) begin
              shadow_dropping = 1'b1;
              shadow_due      = cmd.len;
            end
            owe_result(STS_REJECT, '0, 1'b1);
          end else begin
            shadow_ring[shadow_wr] = BYTE_W'(cmd.len);
            shadow_wr++;
            if (cmd.len != 0) begin
              shadow_open = 1'b1;
              shadow_due  = cmd.len;
            end
            owe_result(STS_ACCEPT, '0, 1'b1);
          end
        end
      end
      OP_PUSH_BYTE: begin
        if (shadow_open) begin
          shadow_ring[shadow_wr] = cmd.data;
          shadow_wr++;
          shadow_due--;
          if (shadow_due == 0) shadow_open = 1'b0;
          owe_result(STS_ACCEPT, '0, 1'b1);
        end else if (shadow_dropping) begin
          // Bytes of a refused packet vanish without a result.
          shadow_due--;
          if (shadow_due == 0) shadow_dropping = 1'b0;
        end
      end
      OP_POP: begin
        // A drop in progress does not hold a pop off; an open push does.
        if (cmd.tx_busy || shadow_rd == shadow_wr || shadow_open) begin
          owe_result(STS_IDLE, '0, 1'b1);
        end else begin
          hdr = shadow_ring[shadow_rd];
          shadow_rd++;
          if (hdr > MAX_LEN) hdr = BYTE_W'(MAX_LEN);
          if (hdr == 0) begin
            owe_result(STS_EMPTY, '0, 1'b1);
          end else begin
            for (int i = 0; i < int'(hdr); i++) begin
              owe_result(STS_BYTE, shadow_ring[shadow_rd], i == int'(hdr) - 1);
              shadow_rd++;
            end
          end
        end
      end
      default: begin
        // The unused code is ignored.
      end
    endcase
  endfunction

  // Queues one command. The value goes to the field that the operation uses;
  // the fields it does not use carry random values so that ignoring them is
  // exercised too.
  function automatic void queue_cmd(input logic [1:0] op, input int unsigned value,
                                    input bit counted);
    fifo_cmd_t cmd;
    cmd.op       = op;
    cmd.len      = LEN_W'($urandom_range(OVER_LEN));
    cmd.data     = BYTE_W'($urandom_range(255));
    cmd.tx_busy  = 1'($urandom_range(1));
    cmd.idle_pct = cur_idle_pct;
    case (op)
      OP_PUSH_START: cmd.len = LEN_W'(value);
      OP_PUSH_BYTE:  cmd.data = BYTE_W'(value);
      OP_POP:        cmd.tx_busy = 1'(value);
      default: ;
    endcase
    pending_cmds.push_back(cmd);
    if (counted) counted_items++;
  endfunction

  // A start followed by some data bytes of random content. Sending fewer
  // bytes than the length leaves the push open on purpose.
  function automatic void push_packet(input int unsigned pkt_len, input int unsigned sent);
    queue_cmd(OP_PUSH_START, pkt_len, 1'b1);
    for (int unsigned i = 0; i < sent; i++)
      queue_cmd(OP_PUSH_BYTE, $urandom_range(255), pkt_len <= MAX_LEN);
  endfunction

  function automatic void build_stimulus();
    int unsigned pick;
    int unsigned pkt_len;
    int unsigned sent;
    int unsigned base;

    // Directed part, run without idling.
    cur_idle_pct = 0;
    queue_cmd(OP_POP, 0, 1'b1);              // pop of an empty ring
    queue_cmd(OP_PUSH_START, 0, 1'b1);       // zero-length packet
    queue_cmd(OP_POP, 0, 1'b1);              // pops as an empty packet
    queue_cmd(OP_PUSH_START, 2, 1'b1);
    queue_cmd(OP_PUSH_BYTE, 8'h00, 1'b1);
    queue_cmd(OP_PUSH_BYTE, 8'hFF, 1'b1);
    queue_cmd(OP_POP, 1, 1'b1);              // transmitter busy blocks the pop
    queue_cmd(OP_PUSH_START, 3, 1'b1);
    queue_cmd(OP_PUSH_BYTE, 8'hA5, 1'b1);
    queue_cmd(OP_PUSH_START, 1, 1'b1);       // start while a push is open
    queue_cmd(OP_POP, 0, 1'b1);              // open push blocks the pop
    queue_cmd(OP_PUSH_BYTE, 8'h5A, 1'b1);
    queue_cmd(OP_PUSH_BYTE, 8'h3C, 1'b1);
    queue_cmd(OP_PUSH_BYTE, 8'h11, 1'b1);    // stray byte with no push
    queue_cmd(OP_UNUSED, 0, 1'b1);
    queue_cmd(OP_PUSH_START, OVER_LEN, 1'b1); // length beyond range
    queue_cmd(OP_PUSH_BYTE, 8'h77, 1'b1);    // dropped
    queue_cmd(OP_POP, 0, 1'b1);              // a drop does not block a pop
    queue_cmd(OP_PUSH_BYTE, 8'h88, 1'b1);    // dropped
    queue_cmd(OP_PUSH_START, 0, 1'b1);       // abandons the drop
    queue_cmd(OP_POP, 0, 1'b1);
    queue_cmd(OP_POP, 0, 1'b1);
    queue_cmd(OP_POP, 0, 1'b1);              // ring is empty again

    // The random part opens on an empty ring with the largest packet, which
    // fills it to the one spare slot, so even an empty packet is refused.
    push_packet(MAX_LEN, MAX_LEN);
    queue_cmd(OP_PUSH_START, 0, 1'b1);
    queue_cmd(OP_POP, 0, 1'b1);

    base = counted_items;
    while (counted_items < base + RANDOM_ITEMS) begin
      // Four idling phases in turn: none, heavy, none again (the receiver
      // cannot stall, so its phase runs flat out), and light.
      case ((counted_items - base) * 4 / RANDOM_ITEMS)
        0:       cur_idle_pct = 0;
        1:       cur_idle_pct = 63;
        2:       cur_idle_pct = 0;
        default: cur_idle_pct = 10;
      endcase
      pick = $urandom_range(99);
      if (pick < 50) begin
        pkt_len = $urandom_range(99);
        if (pkt_len < 5)      pkt_len = $urandom_range(MAX_LEN, 24);
        else if (pkt_len < 9) pkt_len = OVER_LEN;
        else                  pkt_len = $urandom_range(8);
        if (pkt_len > MAX_LEN)             sent = $urandom_range(5, 1);
        else if ($urandom_range(99) < 8)   sent = $urandom_range(pkt_len);
        else                               sent = pkt_len;
        push_packet(pkt_len, sent);
      end else if (pick < 88) begin
        queue_cmd(OP_POP, $urandom_range(9) == 0, 1'b1);
      end else if (pick < 94) begin
        queue_cmd(OP_PUSH_BYTE, $urandom_range(255), 1'b0);
      end else begin
        queue_cmd(OP_UNUSED, 0, 1'b0);
      end
    end
  endfunction

  // Driver. A transfer happens at an edge with start high and busy low; the
  // shadow ring is updated right there with the command that was on the
  // ports. While busy holds a command off, everything stays put.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        predict_fifo_op(pending_cmds[0]);
        void'(pending_cmds.pop_front());
      end
      if (pending_cmds.size() != 0 && $urandom_range(99) >= pending_cmds[0].idle_pct) begin
        start         <= 1'b1;
        in_op         <= pending_cmds[0].op;
        in_pkt_length <= pending_cmds[0].len;
        in_data_in    <= pending_cmds[0].data;
        in_tx_busy    <= pending_cmds[0].tx_busy;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. Each strobed result is matched against the oldest prediction.
  always @(posedge clk) begin
    fifo_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d data=%02h last=%0b",
                                  out_status, out_data_out, out_last));
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.status || out_data_out !== want.data ||
            out_last !== want.last)
          report_mismatch($sformatf("got status=%0d data=%02h last=%0b, want %0d %02h %0b",
                                    out_status, out_data_out, out_last,
                                    want.status, want.data, want.last));
      end
    end
  end

  // Watchdog. Any transfer on either side counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("length_prefixed_packet_fifo regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    build_stimulus();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_cmds.size() != 0) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    // Leave room for any stray result that the block might still produce.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("length_prefixed_packet_fifo regression: pass");
    end else begin
      $display("length_prefixed_packet_fifo regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== length_prefixed_packet_fifo.f =====
design/lppf_pkg.sv
design/lppf_ctrl.sv
design/lppf_datapath.sv
design/length_prefixed_packet_fifo.sv
test/length_prefixed_packet_fifo_test.sv
